// File: rtl/dsa_pkg.sv
// Shared types and constants for the DMA slot priority arbiter.
// Holds the transaction structs, command codes, control bit positions and priority table.
// No dependencies.
`default_nettype none

package dsa_pkg;

    // Command codes
    localparam logic [1:0] CMD_SLOT  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Control register layout
    localparam int unsigned CTRL_W      = 11;
    localparam logic [10:0] CTRL_MASK   = 11'h7ff;
    localparam int unsigned BIT_DISK    = 4;
    localparam int unsigned BIT_SPRITE  = 5;
    localparam int unsigned BIT_BLIT    = 6;
    localparam int unsigned BIT_COPPER  = 7;
    localparam int unsigned BIT_BPL     = 8;
    localparam int unsigned BIT_MASTER  = 9;
    localparam int unsigned BIT_BLTPRI  = 10;

    // Write word and read word bit positions
    localparam int unsigned WR_SET_BIT   = 15;
    localparam int unsigned RD_BUSY_BIT  = 14;
    localparam int unsigned RD_ZERO_BIT  = 13;

    // Source numbering
    localparam int unsigned SRC_COUNT = 21;
    localparam logic [4:0]  SRC_BLIT  = 5'd20;

    typedef logic [4:0] t_src;

    // Sources in priority order, highest first
    localparam t_src PRIO_ORDER [SRC_COUNT] = '{
        5'd0,  5'd4,  5'd3,  5'd2,  5'd1,
        5'd12, 5'd11, 5'd10, 5'd9,  5'd8,  5'd7,  5'd6,  5'd5,
        5'd18, 5'd17, 5'd16, 5'd15, 5'd14, 5'd13,
        5'd19, 5'd20
    };

    typedef struct packed {
        logic [1:0]  command;
        logic [20:0] request_vector;
        logic [15:0] write_value;
        logic        blt_busy;
        logic        blt_zero;
    } t_dsa_in;

    typedef struct packed {
        logic        grant_valid;
        logic [4:0]  grant_source;
        logic [15:0] read_data;
        logic [31:0] slot_count;
        logic [31:0] grant_count;
    } t_dsa_out;

    // Grant decision handed from the picker to the top level
    typedef struct packed {
        logic valid;
        t_src source;
    } t_dsa_grant;

endpackage

`default_nettype wire

// File: rtl/dsa_pick.sv
// Request masking and fixed-priority pick for one DMA slot.
// Depends on dsa_pkg for control bit positions and the priority table.
`default_nettype none

module dsa_pick (
    input  wire logic [10:0]         i_ctrl,
    input  wire logic [20:0]         i_req,
    input  wire logic                i_busy,
    output dsa_pkg::t_dsa_grant      o_grant
);
    import dsa_pkg::*;

    logic [20:0] masked;
    t_dsa_grant  scan;

    // Mask requests by master, channel enables and blitter busy
    always_comb begin
        masked = '0;
        if (i_ctrl[BIT_MASTER]) begin
            masked[0]     = i_req[0] & i_ctrl[BIT_DISK];
            masked[4:1]   = i_req[4:1] & i_ctrl[3:0];
            masked[12:5]  = i_req[12:5] & {8{i_ctrl[BIT_SPRITE]}};
            masked[18:13] = i_req[18:13] & {6{i_ctrl[BIT_BPL]}};
            masked[19]    = i_req[19] & i_ctrl[BIT_COPPER];
            masked[20]    = i_req[20] & i_ctrl[BIT_BLIT] & i_busy;
        end
    end

    // Scan from lowest priority up so the highest request is kept
    always_comb begin
        scan = '0;
        for (int i = SRC_COUNT - 1; i >= 0; i--) begin
            if (masked[PRIO_ORDER[i]]) begin
                scan.valid  = 1'b1;
                scan.source = PRIO_ORDER[i];
            end
        end
    end

    // Blitter priority moves the blitter to the front
    always_comb begin
        if (i_ctrl[BIT_BLTPRI] && masked[SRC_BLIT]) begin
            o_grant.valid  = 1'b1;
            o_grant.source = SRC_BLIT;
        end else begin
            o_grant = scan;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dma_slot_priority_arbiter.sv
// Top level of the DMA slot priority arbiter: input register, control state, result register.
// Depends on dsa_pkg and dsa_pick.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one command per transaction:
//   arbitrate a slot, write the control register (set or clear masked bits) or read it.
//   Output channel (o_out_valid / i_out_stall / o_out) returns exactly one result per
//   input transaction, in order: grant, read data and both running counters.
//   Each transaction passes through the input register, then the mask, priority pick
//   and counter updates settle into the result register. Throughput is one transaction
//   per cycle while the receiver does not stall; the priority encoder and the 32-bit
//   counter incrementers lie between the two registers.
//   When the receiver stalls, the result register holds its transaction; the input
//   register keeps accepting until it is full, then o_in_stall rises.
//   Reset (i_rst_n low, synchronous) empties both stages and clears the control
//   register and both counters.
`default_nettype none

module dma_slot_priority_arbiter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output wire logic              o_in_stall,
    input  wire dsa_pkg::t_dsa_in  i_in,
    output wire logic              o_out_valid,
    input  wire logic              i_out_stall,
    output wire dsa_pkg::t_dsa_out o_out
);
    import dsa_pkg::*;

    logic        r_in_valid;
    t_dsa_in     r_in;
    logic        r_out_valid;
    t_dsa_out    r_out;
    logic [10:0] r_ctrl;
    logic [31:0] r_slots;
    logic [31:0] r_grants;

    logic [10:0] n_ctrl;
    logic [31:0] n_slots;
    logic [31:0] n_grants;
    t_dsa_out    n_out;

    logic        out_adv;
    logic        in_adv;
    logic [10:0] wr_mask;
    t_dsa_grant  grant;

    // Stage handshakes
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign in_adv     = !r_in_valid || out_adv;
    assign o_in_stall = !in_adv;

    dsa_pick u_pick (
        .i_ctrl  (r_ctrl),
        .i_req   (r_in.request_vector),
        .i_busy  (r_in.blt_busy),
        .o_grant (grant)
    );

    assign wr_mask = r_in.write_value[10:0] & CTRL_MASK;

    // Execute the registered command against current state
    always_comb begin
        n_ctrl   = r_ctrl;
        n_slots  = r_slots;
        n_grants = r_grants;
        n_out    = '0;
        case (r_in.command)
            CMD_SLOT: begin
                n_slots = r_slots + 32'd1;
                if (grant.valid) begin
                    n_grants           = r_grants + 32'd1;
                    n_out.grant_valid  = 1'b1;
                    n_out.grant_source = grant.source;
                end
            end
            CMD_WRITE: begin
                if (r_in.write_value[WR_SET_BIT]) begin
                    n_ctrl = r_ctrl | wr_mask;
                end else begin
                    n_ctrl = r_ctrl & ~wr_mask;
                end
            end
            CMD_READ: begin
                n_out.read_data[CTRL_W-1:0] = r_ctrl;
                n_out.read_data[RD_BUSY_BIT] = r_in.blt_busy;
                n_out.read_data[RD_ZERO_BIT] = r_in.blt_zero;
            end
            default: begin
            end
        endcase
        n_out.slot_count  = n_slots;
        n_out.grant_count = n_grants;
    end

    // Control state and stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctrl      <= '0;
            r_slots     <= '0;
            r_grants    <= '0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (out_adv && r_in_valid) begin
                r_ctrl   <= n_ctrl;
                r_slots  <= n_slots;
                r_grants <= n_grants;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_in <= i_in;
        end
        if (out_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
